### rtl/core/pidfd_pkg.sv
// Shared types, constants and saturating helpers for the filtered-derivative PID block.
`timescale 1ns / 1ps
package pidfd_pkg;

  localparam int DW      = 32;
  localparam int FRAC    = 16;
  localparam int OP_W    = DW + 1;
  localparam int PROD_W  = 2 * OP_W;
  localparam int LIM_W   = 31;
  localparam int COEF_W  = 17;
  localparam int ADDR_W  = 3;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  // Register indexes of the configuration port.
  localparam logic [ADDR_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [ADDR_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [ADDR_W-1:0] REG_INT_LIMIT  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_INT_RANGE  = 3'd4;
  localparam logic [ADDR_W-1:0] REG_STEP_DT    = 3'd5;
  localparam logic [ADDR_W-1:0] REG_INV_DT     = 3'd6;
  localparam logic [ADDR_W-1:0] REG_ALPHA      = 3'd7;

  typedef struct packed {
    logic signed [DW-1:0] prop_gain;
    logic signed [DW-1:0] integ_gain;
    logic signed [DW-1:0] deriv_gain;
    logic [LIM_W-1:0]     integral_limit;
    logic [LIM_W-1:0]     integral_range;
    logic [COEF_W-1:0]    step_dt;
    logic [LIM_W-1:0]     inv_dt;
    logic [COEF_W-1:0]    filter_alpha;
  } cfg_regs_t;

  // Sum or difference of two words, saturated to the word range.
  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b,
                                                   input logic sub);
    logic signed [DW:0] s;
    s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? MINV : MAXV;
    end
    return s[DW-1:0];
  endfunction

  // Clamp a word to plus or minus a non-negative magnitude.
  function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] s,
                                                 input logic [LIM_W-1:0] lim);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = $signed({{(DW-LIM_W){1'b0}}, lim});
    lo = -hi;
    if (s > hi) return hi;
    if (s < lo) return lo;
    return s;
  endfunction

  function automatic logic signed [OP_W-1:0] ext_s(input logic signed [DW-1:0] x);
    return {x[DW-1], x};
  endfunction

  function automatic logic signed [OP_W-1:0] ext_c(input logic [COEF_W-1:0] x);
    return $signed({{(OP_W-COEF_W){1'b0}}, x});
  endfunction

  function automatic logic signed [OP_W-1:0] ext_l(input logic [LIM_W-1:0] x);
    return $signed({{(OP_W-LIM_W){1'b0}}, x});
  endfunction

endpackage

### rtl/core/pid_filtered_derivative.sv
// Top level of the PID channel with clamped integral and low-pass derivative.
`timescale 1ns / 1ps
// One PID channel in signed Q16.16. Each request carries an error source in in_tuser
// (0: reference minus measurement, 1: supplied error) and yields one saturated drive
// value. All six products go through a single registered multiplier under a small
// sequencer, so a request occupies the block from acceptance through eight sequencer
// steps, ST_MUL_I to ST_DONE, to the result register; in_tready is high only while
// the sequencer is idle. The result sits in an output register, so the next request is
// accepted while it waits; the sequencer only holds in its last step if a previous
// result has still not been taken. Configuration writes take effect on the next edge
// and should be made while no request is in flight.
module pid_filtered_derivative (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [95:0]                   in_tdata,   // reference, measurement, supplied_error
  input  logic                          in_tuser,   // op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // drive
  input  logic                          cfg_we,
  input  logic [pidfd_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [pidfd_pkg::DW-1:0]      cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_I, ST_MUL_RAW, ST_SUB_D, ST_MUL_F,
    ST_MUL_P, ST_MUL_KI, ST_MUL_KD, ST_DONE
  } state_t;

  typedef logic signed [pidfd_pkg::DW-1:0] word_t;

  pidfd_pkg::cfg_regs_t regs;

  state_t st_r, st_nxt;
  word_t  e_r, e_nxt;
  word_t  diff_r, diff_nxt;
  word_t  dd_r, dd_nxt;
  word_t  d_r, d_nxt;
  word_t  acc_r, acc_nxt;
  word_t  int_r, int_nxt;
  word_t  last_e_r, last_e_nxt;
  word_t  last_d_r, last_d_nxt;
  word_t  out_data_r, out_data_nxt;
  logic   en_r, en_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic signed [pidfd_pkg::OP_W-1:0] mul_a, mul_b;
  word_t                             q;
  word_t                             in_ref, in_meas, in_sup;
  logic [pidfd_pkg::DW-1:0]          mag;

  pidfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  pidfd_qmul u_qmul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (q)
  );

  assign in_ref  = $signed(in_tdata[31:0]);
  assign in_meas = $signed(in_tdata[63:32]);
  assign in_sup  = $signed(in_tdata[95:64]);

  // Magnitude as an unsigned word, so the most negative error maps to 2^31.
  assign mag = e_r[pidfd_pkg::DW-1] ? (~e_r + 1'b1) : e_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r) inside
      ST_MUL_I: begin
        mul_a = pidfd_pkg::ext_s(e_r);
        mul_b = pidfd_pkg::ext_c(regs.step_dt);
      end
      ST_MUL_RAW: begin
        mul_a = pidfd_pkg::ext_s(diff_r);
        mul_b = pidfd_pkg::ext_l(regs.inv_dt);
      end
      ST_MUL_F: begin
        mul_a = pidfd_pkg::ext_c(regs.filter_alpha);
        mul_b = pidfd_pkg::ext_s(dd_r);
      end
      ST_MUL_P: begin
        mul_a = pidfd_pkg::ext_s(regs.prop_gain);
        mul_b = pidfd_pkg::ext_s(e_r);
      end
      ST_MUL_KI: begin
        mul_a = pidfd_pkg::ext_s(regs.integ_gain);
        mul_b = pidfd_pkg::ext_s(int_r);
      end
      ST_MUL_KD, ST_DONE: begin
        // The last product is held here while the result waits for the output register.
        mul_a = pidfd_pkg::ext_s(regs.deriv_gain);
        mul_b = pidfd_pkg::ext_s(d_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    e_nxt         = e_r;
    diff_nxt      = diff_r;
    dd_nxt        = dd_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    int_nxt       = int_r;
    last_e_nxt    = last_e_r;
    last_d_nxt    = last_d_r;
    en_nxt        = en_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          e_nxt  = in_tuser ? in_sup : pidfd_pkg::sat_add(in_ref, in_meas, 1'b1);
          st_nxt = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        en_nxt   = (mag < {1'b0, regs.integral_range}) && (regs.integ_gain > 0);
        diff_nxt = pidfd_pkg::sat_add(e_r, last_e_r, 1'b1);
        st_nxt   = ST_MUL_RAW;
      end
      ST_MUL_RAW: begin
        if (en_r) begin
          int_nxt = pidfd_pkg::clamp(pidfd_pkg::sat_add(int_r, q, 1'b0),
                                     regs.integral_limit);
        end
        st_nxt = ST_SUB_D;
      end
      ST_SUB_D: begin
        dd_nxt = pidfd_pkg::sat_add(q, last_d_r, 1'b1);
        st_nxt = ST_MUL_F;
      end
      ST_MUL_F: begin
        st_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        d_nxt      = pidfd_pkg::sat_add(last_d_r, q, 1'b0);
        last_d_nxt = pidfd_pkg::sat_add(last_d_r, q, 1'b0);
        last_e_nxt = e_r;
        st_nxt     = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        acc_nxt = q;
        st_nxt  = ST_MUL_KD;
      end
      ST_MUL_KD: begin
        acc_nxt = pidfd_pkg::sat_add(acc_r, q, 1'b0);
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = pidfd_pkg::sat_add(acc_r, q, 1'b0);
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      int_r       <= '0;
      last_e_r    <= '0;
      last_d_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      int_r       <= int_nxt;
      last_e_r    <= last_e_nxt;
      last_d_r    <= last_d_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r        <= e_nxt;
    diff_r     <= diff_nxt;
    dd_r       <= dd_nxt;
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    en_r       <= en_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/pidfd_cfg.sv
// Configuration register file for the filtered-derivative PID block.
`timescale 1ns / 1ps
module pidfd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pidfd_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [pidfd_pkg::DW-1:0]      cfg_wdata,
  output pidfd_pkg::cfg_regs_t          regs
);

  pidfd_pkg::cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.prop_gain      <= 32'sd65536;
      regs_r.integ_gain     <= '0;
      regs_r.deriv_gain     <= '0;
      regs_r.integral_limit <= '1;
      regs_r.integral_range <= '1;
      regs_r.step_dt        <= 17'd131;
      regs_r.inv_dt         <= 31'd32768000;
      regs_r.filter_alpha   <= 17'd13160;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pidfd_pkg::REG_PROP_GAIN:  regs_r.prop_gain  <= $signed(cfg_wdata);
        pidfd_pkg::REG_INTEG_GAIN: regs_r.integ_gain <= $signed(cfg_wdata);
        pidfd_pkg::REG_DERIV_GAIN: regs_r.deriv_gain <= $signed(cfg_wdata);
        pidfd_pkg::REG_INT_LIMIT:  regs_r.integral_limit <= cfg_wdata[pidfd_pkg::LIM_W-1:0];
        pidfd_pkg::REG_INT_RANGE:  regs_r.integral_range <= cfg_wdata[pidfd_pkg::LIM_W-1:0];
        pidfd_pkg::REG_STEP_DT:    regs_r.step_dt <= cfg_wdata[pidfd_pkg::COEF_W-1:0];
        pidfd_pkg::REG_INV_DT:     regs_r.inv_dt  <= cfg_wdata[pidfd_pkg::LIM_W-1:0];
        pidfd_pkg::REG_ALPHA:      regs_r.filter_alpha <= cfg_wdata[pidfd_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

### rtl/core/pidfd_qmul.sv
// Shared fixed-point multiplier: exact product, floor shift, saturation, registered.
`timescale 1ns / 1ps
module pidfd_qmul (
  input  logic                              clk,
  input  logic signed [pidfd_pkg::OP_W-1:0] a,
  input  logic signed [pidfd_pkg::OP_W-1:0] b,
  output logic signed [pidfd_pkg::DW-1:0]   q
);

  localparam int SH_W = pidfd_pkg::PROD_W - pidfd_pkg::FRAC;

  logic signed [pidfd_pkg::PROD_W-1:0] prod;
  logic signed [SH_W-1:0]              shifted;
  logic signed [pidfd_pkg::DW-1:0]     sat_q;
  logic signed [pidfd_pkg::DW-1:0]     q_r;

  // Dropping the low fraction bits of a two's complement product rounds toward
  // minus infinity.
  assign prod    = $signed({{pidfd_pkg::OP_W{a[pidfd_pkg::OP_W-1]}}, a}) *
                   $signed({{pidfd_pkg::OP_W{b[pidfd_pkg::OP_W-1]}}, b});
  assign shifted = prod[pidfd_pkg::PROD_W-1:pidfd_pkg::FRAC];

  always_comb begin
    if (shifted[SH_W-1:pidfd_pkg::DW-1] == '0 || shifted[SH_W-1:pidfd_pkg::DW-1] == '1) begin
      sat_q = shifted[pidfd_pkg::DW-1:0];
    end else begin
      sat_q = shifted[SH_W-1] ? pidfd_pkg::MINV : pidfd_pkg::MAXV;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= sat_q;
  end

  assign q = q_r;

endmodule
